// ===== sv/tpsc_pkg.sv =====
// shared types and constants for the two-point sensor calibration block
`timescale 1ns / 1ps
`default_nettype none

package tpsc_pkg;

  // field and datapath widths
  localparam int RAW_W     = 16;  // raw sample and raw calibration points
  localparam int PT_W      = 7;   // calibration points in degrees or percent
  localparam int SPAN_W    = 17;  // difference of two raw values
  localparam int SLOPE_W   = 8;   // difference of two calibration points
  localparam int PROD_W    = 25;  // products of the front end
  localparam int SUM_W     = 26;  // sum of the two products
  localparam int NUM_W     = 30;  // numerator scaled to tenths
  localparam int MAG_W     = 29;  // rounding dividend and quotient magnitude
  localparam int DMAG_W    = 16;  // magnitude of the raw span
  localparam int DIV_W     = 17;  // doubled span, divisor of the rounding division
  localparam int VAL_W     = 24;  // result in tenths
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // quantity selector
  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_HUM  = 1'b1;

  // saturation bounds on the quotient magnitude
  localparam logic [MAG_W-1:0] SAT_POS_MAG = MAG_W'(8388607);
  localparam logic [MAG_W-1:0] SAT_NEG_MAG = MAG_W'(8388608);
  localparam logic [VAL_W-1:0] VAL_MAX     = VAL_W'(8388607);
  localparam logic [VAL_W-1:0] VAL_MIN     = VAL_W'(8388608);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_P0_PCT  = 3'd0,
    REG_HUM_P1_PCT  = 3'd1,
    REG_HUM_P0_RAW  = 3'd2,
    REG_HUM_P1_RAW  = 3'd3,
    REG_TEMP_P0_DEG = 3'd4,
    REG_TEMP_P1_DEG = 3'd5,
    REG_TEMP_P0_RAW = 3'd6,
    REG_TEMP_P1_RAW = 3'd7
  } cfg_index_e;

  // input word
  typedef struct packed {
    logic                     cmd;
    logic signed [RAW_W-1:0]  raw_sample;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [VAL_W-1:0]  value_tenths;
    logic                     zero_span_error;
  } out_word_t;

  // queue entry between front and back
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;   // (sample - raw0) * (pt1 - pt0)
    logic signed [PROD_W-1:0] offs;   // pt0 * (raw1 - raw0)
    logic signed [SPAN_W-1:0] span;   // raw1 - raw0
    logic                     zero;   // span is zero
  } q_entry_t;

endpackage

`default_nettype wire

// ===== sv/tpsc_front.sv =====
// front end: calibration registers, set selection and the two products
`timescale 1ns / 1ps
`default_nettype none

module tpsc_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire tpsc_pkg::in_word_t               in_word,
  input  wire logic                             wr_en,
  input  wire logic [tpsc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [tpsc_pkg::CFG_DAT_W-1:0]   wr_data,
  output logic                                  push,
  output tpsc_pkg::q_entry_t                    entry,
  output logic [1:0]                            inflight
);
  import tpsc_pkg::*;

  logic [PT_W-1:0]          hum_p0_pct;
  logic [PT_W-1:0]          hum_p1_pct;
  logic signed [RAW_W-1:0]  hum_p0_raw;
  logic signed [RAW_W-1:0]  hum_p1_raw;
  logic [PT_W-1:0]          temp_p0_deg;
  logic [PT_W-1:0]          temp_p1_deg;
  logic signed [RAW_W-1:0]  temp_p0_raw;
  logic signed [RAW_W-1:0]  temp_p1_raw;

  logic [PT_W-1:0]          sel_p0;
  logic [PT_W-1:0]          sel_p1;
  logic signed [RAW_W-1:0]  sel_r0;
  logic signed [RAW_W-1:0]  sel_r1;
  logic signed [SPAN_W-1:0] diff_next;
  logic signed [SPAN_W-1:0] span_next;
  logic signed [SLOPE_W-1:0] slope_next;

  // stage one registers
  logic                     v1;
  logic signed [SPAN_W-1:0] diff1;
  logic signed [SPAN_W-1:0] span1;
  logic signed [SLOPE_W-1:0] slope1;
  logic [PT_W-1:0]          p0_1;
  logic signed [SLOPE_W-1:0] p0_ext;

  // stage two registers
  logic                     v2;
  logic signed [PROD_W-1:0] prod2;
  logic signed [PROD_W-1:0] offs2;
  logic signed [SPAN_W-1:0] span2;
  logic                     zero2;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hum_p0_pct  <= '0;
      hum_p1_pct  <= '0;
      hum_p0_raw  <= '0;
      hum_p1_raw  <= '0;
      temp_p0_deg <= '0;
      temp_p1_deg <= '0;
      temp_p0_raw <= '0;
      temp_p1_raw <= '0;
    end else if (wr_en) begin
      unique case (cfg_index_e'(wr_index))
        REG_HUM_P0_PCT:  hum_p0_pct  <= wr_data[PT_W-1:0];
        REG_HUM_P1_PCT:  hum_p1_pct  <= wr_data[PT_W-1:0];
        REG_HUM_P0_RAW:  hum_p0_raw  <= wr_data;
        REG_HUM_P1_RAW:  hum_p1_raw  <= wr_data;
        REG_TEMP_P0_DEG: temp_p0_deg <= wr_data[PT_W-1:0];
        REG_TEMP_P1_DEG: temp_p1_deg <= wr_data[PT_W-1:0];
        REG_TEMP_P0_RAW: temp_p0_raw <= wr_data;
        REG_TEMP_P1_RAW: temp_p1_raw <= wr_data;
      endcase
    end
  end

  // pick the calibration set and form the differences
  always_comb begin
    if (in_word.cmd == CMD_HUM) begin
      sel_p0 = hum_p0_pct;
      sel_p1 = hum_p1_pct;
      sel_r0 = hum_p0_raw;
      sel_r1 = hum_p1_raw;
    end else begin
      sel_p0 = temp_p0_deg;
      sel_p1 = temp_p1_deg;
      sel_r0 = temp_p0_raw;
      sel_r1 = temp_p1_raw;
    end
    diff_next  = {in_word.raw_sample[RAW_W-1], in_word.raw_sample} - {sel_r0[RAW_W-1], sel_r0};
    span_next  = {sel_r1[RAW_W-1], sel_r1} - {sel_r0[RAW_W-1], sel_r0};
    slope_next = {1'b0, sel_p1} - {1'b0, sel_p0};
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    diff1  <= diff_next;
    span1  <= span_next;
    slope1 <= slope_next;
    p0_1   <= sel_p0;
  end

  assign p0_ext = {1'b0, p0_1};

  // stage two: the two products
  always_ff @(posedge clk) begin
    prod2 <= diff1 * slope1;
    offs2 <= p0_ext * span1;
    span2 <= span1;
    zero2 <= (span1 == '0);
  end

  assign push     = v2;
  assign entry    = '{prod: prod2, offs: offs2, span: span2, zero: zero2};
  assign inflight = {1'b0, v1} + {1'b0, v2};

endmodule

`default_nettype wire

// ===== sv/tpsc_queue.sv =====
// short word queue between the front end and the divider
`timescale 1ns / 1ps
`default_nettype none

module tpsc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire tpsc_pkg::q_entry_t           wr_entry,
  input  wire logic                         pop,
  output tpsc_pkg::q_entry_t                rd_entry,
  output logic [$clog2(DEPTH+1)-1:0]        count,
  output logic                              empty
);
  import tpsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  q_entry_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign rd_entry = slots[rd_ptr];
  assign empty    = (count == '0);

  // no overflow, no underflow, count tracks the traffic
  assert property (@(posedge clk) disable iff (rst) push |-> (count < CNT_W'(DEPTH) || pop))
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CNT_W'($past(push)) - CNT_W'($past(pop)))
    else $error("queue count out of step");

endmodule

`default_nettype wire

// ===== sv/tpsc_back.sv =====
// back end: tenths scaling, pipelined rounding division and saturation
`timescale 1ns / 1ps
`default_nettype none

module tpsc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pop,
  input  wire tpsc_pkg::q_entry_t   entry,
  output logic                      done,
  output tpsc_pkg::out_word_t       result
);
  import tpsc_pkg::*;

  // one quotient bit per divider stage
  localparam int QW = MAG_W;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [MAG_W-1:0] dvd;
    logic [MAG_W-1:0] quo;
    logic [DIV_W-1:0] dv;
    logic             neg;
    logic             zero;
  } div_stage_t;

  // scaling stage
  logic                     v0;
  logic signed [NUM_W-1:0]  num0;
  logic signed [SPAN_W-1:0] span0;
  logic                     zero0;
  logic signed [SUM_W-1:0]  sum;
  logic signed [NUM_W-1:0]  sum_ext;

  // operand stage
  logic [NUM_W-1:0]         nmag_full;
  logic [SPAN_W-1:0]        dmag_full;
  logic [MAG_W-2:0]         nmag;
  logic [DMAG_W-1:0]        dmag;

  // divider stages
  logic                     stv [QW+1];
  div_stage_t               st  [QW+1];

  // output
  logic [MAG_W-1:0]         q;
  logic [VAL_W-1:0]         val_next;

  // numerator scaled to tenths
  assign sum     = {entry.prod[PROD_W-1], entry.prod} + {entry.offs[PROD_W-1], entry.offs};
  assign sum_ext = NUM_W'(sum);

  always_ff @(posedge clk) begin
    num0  <= (sum_ext <<< 3) + (sum_ext <<< 1);
    span0 <= entry.span;
    zero0 <= entry.zero;
  end

  // magnitudes and the rounding dividend 2|num| + |span|
  assign nmag_full = num0[NUM_W-1] ? -num0 : num0;
  assign dmag_full = span0[SPAN_W-1] ? -span0 : span0;
  assign nmag      = nmag_full[MAG_W-2:0];
  assign dmag      = dmag_full[DMAG_W-1:0];

  always_ff @(posedge clk) begin
    st[0].rem  <= '0;
    st[0].dvd  <= {nmag, 1'b0} + MAG_W'(dmag);
    st[0].quo  <= '0;
    st[0].dv   <= {dmag, 1'b0};
    st[0].neg  <= num0[NUM_W-1] ^ span0[SPAN_W-1];
    st[0].zero <= zero0;
  end

  // valid bits of the scaling and operand stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      stv[0] <= 1'b0;
    end else begin
      v0     <= pop;
      stv[0] <= v0;
    end
  end

  // restoring division, one quotient bit a stage
  for (genvar g = 0; g < QW; g++) begin : gen_div
    logic [DIV_W:0] trial;
    logic           ge;

    assign trial = {st[g].rem, st[g].dvd[MAG_W-1]};
    assign ge    = (trial >= {1'b0, st[g].dv});

    always_ff @(posedge clk) begin
      st[g+1].rem  <= ge ? DIV_W'(trial - {1'b0, st[g].dv}) : trial[DIV_W-1:0];
      st[g+1].dvd  <= {st[g].dvd[MAG_W-2:0], 1'b0};
      st[g+1].quo  <= {st[g].quo[MAG_W-2:0], ge};
      st[g+1].dv   <= st[g].dv;
      st[g+1].neg  <= st[g].neg;
      st[g+1].zero <= st[g].zero;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stv[g+1] <= 1'b0;
      end else begin
        stv[g+1] <= stv[g];
      end
    end
  end

  // sign and saturation
  assign q = st[QW].quo;

  always_comb begin
    if (st[QW].zero) begin
      val_next = '0;
    end else if (st[QW].neg) begin
      val_next = (q > SAT_NEG_MAG) ? VAL_MIN : VAL_W'(-q);
    end else begin
      val_next = (q > SAT_POS_MAG) ? VAL_MAX : q[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stv[QW];
    end
  end

  always_ff @(posedge clk) begin
    result.value_tenths    <= val_next;
    result.zero_span_error <= st[QW].zero;
  end

  // every popped word leaves the back end with done raised
  assert property (@(posedge clk) disable iff (rst) pop |-> ##(QW+3) done)
    else $error("word lost in back end");
  // divider remainder stays below the divisor for a real span
  assert property (@(posedge clk) disable iff (rst)
    (stv[QW] && !st[QW].zero) |-> (st[QW].rem < st[QW].dv))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

// ===== sv/two_point_sensor_calibration.sv =====
// top level of the two-point sensor calibration block
`timescale 1ns / 1ps
`default_nettype none

// Converts a signed 16-bit raw sample to tenths of a degree or percent by
// linear interpolation between two calibration points, rounded to nearest
// with halves away from zero and saturated to 24 bits; equal raw points give
// zero with zero_span_error set. A new word can be started on every clock:
// busy stays low as long as the back end drains the queue, which it does
// every cycle since results cannot be held off. The result appears on
// result with done high for one cycle; on the way it passes the first
// front-end stage, which takes the word at the start edge itself, the second
// front-end stage, the queue, three back-end stages and the 29-stage
// pipelined divider, one quotient bit a stage. Write the calibration
// registers only while no conversion is in flight.
module two_point_sensor_calibration #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire tpsc_pkg::in_word_t               in_word,
  output logic                                  done,
  output tpsc_pkg::out_word_t                   result,
  input  wire logic                             wr_en,
  input  wire logic [tpsc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [tpsc_pkg::CFG_DAT_W-1:0]   wr_data
);
  import tpsc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
  localparam int OCC_W = CNT_W + 1;

  logic             accept;
  logic             push;
  logic             pop;
  logic             empty;
  logic [1:0]       inflight;
  logic [CNT_W-1:0] q_count;
  logic [OCC_W-1:0] occupancy;
  q_entry_t         wr_entry;
  q_entry_t         rd_entry;

  // hold off start when the queue could not take every word in flight
  assign occupancy = OCC_W'(q_count) + OCC_W'(inflight);
  assign busy      = (occupancy >= OCC_W'(QUEUE_DEPTH));
  assign accept    = start && !busy;
  assign pop       = !empty;

  tpsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_word  (in_word),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .push     (push),
    .entry    (wr_entry),
    .inflight (inflight)
  );

  tpsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .count    (q_count),
    .empty    (empty)
  );

  tpsc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .pop    (pop),
    .entry  (rd_entry),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== test/calibration_checker.sv =====
// checker for the calibration block: predicts each result word and compares it
`timescale 1ns / 1ps

module calibration_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  tpsc_pkg::in_word_t               in_word,
  input  logic                             done,
  input  tpsc_pkg::out_word_t              result,
  input  logic                             wr_en,
  input  logic [tpsc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [tpsc_pkg::CFG_DAT_W-1:0]   wr_data,
  output int                               fail_count,
  output int                               outstanding
);

  import tpsc_pkg::*;

  localparam longint TENTHS_MAX  = 8388607;
  localparam longint TENTHS_MIN  = -8388608;
  localparam int     PRINT_LIMIT = 100;

  // own copy of the calibration registers
  logic [PT_W-1:0]         hum_pct0, hum_pct1, temp_deg0, temp_deg1;
  logic signed [RAW_W-1:0] hum_raw0, hum_raw1, temp_raw0, temp_raw1;

  // result words still to come, oldest first
  out_word_t expected_words[$];

  // interpolate one sample between the two points of the chosen set
  function automatic out_word_t calibrate_sample(in_word_t w);
    longint    pt0, pt1, raw0, raw1, span, num, quo, smp;
    out_word_t r;
    r   = '0;
    smp = longint'(w.raw_sample);
    if (w.cmd == CMD_HUM) begin
      pt0  = longint'(hum_pct0);
      pt1  = longint'(hum_pct1);
      raw0 = longint'(hum_raw0);
      raw1 = longint'(hum_raw1);
    end else begin
      pt0  = longint'(temp_deg0);
      pt1  = longint'(temp_deg1);
      raw0 = longint'(temp_raw0);
      raw1 = longint'(temp_raw1);
    end
    span = raw1 - raw0;
    // equal raw points: no span to divide by
    if (span == 0) begin
      r.zero_span_error = 1'b1;
      return r;
    end
    num = 10 * ((smp - raw0) * (pt1 - pt0) + pt0 * span);
    if (span < 0) begin
      span = -span;
      num  = -num;
    end
    // round to nearest, halves away from zero
    if (num >= 0) quo = (2 * num + span) / (2 * span);
    else quo = -((2 * (-num) + span) / (2 * span));
    if (quo > TENTHS_MAX) quo = TENTHS_MAX;
    if (quo < TENTHS_MIN) quo = TENTHS_MIN;
    r.value_tenths = VAL_W'(quo);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst) begin
      expected_words.delete();
      outstanding <= 0;
      fail_count  <= 0;
      hum_pct0    <= '0;
      hum_pct1    <= '0;
      hum_raw0    <= '0;
      hum_raw1    <= '0;
      temp_deg0   <= '0;
      temp_deg1   <= '0;
      temp_raw0   <= '0;
      temp_raw1   <= '0;
    end else begin
      // register writes, upper bits beyond the register dropped
      if (wr_en) begin
        case (cfg_index_e'(wr_index))
          REG_HUM_P0_PCT:  hum_pct0  <= wr_data[PT_W-1:0];
          REG_HUM_P1_PCT:  hum_pct1  <= wr_data[PT_W-1:0];
          REG_HUM_P0_RAW:  hum_raw0  <= wr_data[RAW_W-1:0];
          REG_HUM_P1_RAW:  hum_raw1  <= wr_data[RAW_W-1:0];
          REG_TEMP_P0_DEG: temp_deg0 <= wr_data[PT_W-1:0];
          REG_TEMP_P1_DEG: temp_deg1 <= wr_data[PT_W-1:0];
          REG_TEMP_P0_RAW: temp_raw0 <= wr_data[RAW_W-1:0];
          REG_TEMP_P1_RAW: temp_raw1 <= wr_data[RAW_W-1:0];
          default: ;
        endcase
      end
      // result word against the oldest expectation
      if (done) begin
        if (expected_words.size() == 0) begin
          if (fail_count < PRINT_LIMIT)
            $display("%0t: unexpected result, expected none, actual value %0d error %0b",
                     $time, result.value_tenths, result.zero_span_error);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.value_tenths !== result.value_tenths ||
              want.zero_span_error !== result.zero_span_error) begin
            if (fail_count < PRINT_LIMIT)
              $display("%0t: mismatch, expected value %0d error %0b, actual value %0d error %0b",
                       $time, want.value_tenths, want.zero_span_error,
                       result.value_tenths, result.zero_span_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      // accepted input word
      if (start && !busy) expected_words.push_back(calibrate_sample(in_word));
      outstanding <= expected_words.size();
    end
  end

endmodule

// ===== test/tb_two_point_sensor_calibration.sv =====
// testbench top for the two-point sensor calibration block: stimulus and verdict
`timescale 1ns / 1ps

module tb_two_point_sensor_calibration;

  import tpsc_pkg::*;

  localparam int     CLK_HALF      = 5;
  localparam int     RESET_CYCLES  = 7;
  localparam int     RANDOM_PHASES = 7;
  localparam int     PHASE_WORDS   = 120;
  localparam int     SETTLE_CYCLES = 40;
  localparam longint TIMEOUT_NS    = 5000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  in_word_t             in_word = '0;
  logic                 done;
  out_word_t            result;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DAT_W-1:0] wr_data = '0;
  int                   fail_count;
  int                   outstanding;

  always #(CLK_HALF) clk = ~clk;

  two_point_sensor_calibration i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  calibration_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .done        (done),
    .result      (result),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // one register write; the caller lowers the enable after the last one
  task automatic write_reg(cfg_index_e idx, logic [CFG_DAT_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_calibration(
    logic [CFG_DAT_W-1:0] hum_p0, logic [CFG_DAT_W-1:0] hum_p1,
    logic [CFG_DAT_W-1:0] hum_r0, logic [CFG_DAT_W-1:0] hum_r1,
    logic [CFG_DAT_W-1:0] temp_p0, logic [CFG_DAT_W-1:0] temp_p1,
    logic [CFG_DAT_W-1:0] temp_r0, logic [CFG_DAT_W-1:0] temp_r1);
    write_reg(REG_HUM_P0_PCT, hum_p0);
    write_reg(REG_HUM_P1_PCT, hum_p1);
    write_reg(REG_HUM_P0_RAW, hum_r0);
    write_reg(REG_HUM_P1_RAW, hum_r1);
    write_reg(REG_TEMP_P0_DEG, temp_p0);
    write_reg(REG_TEMP_P1_DEG, temp_p1);
    write_reg(REG_TEMP_P0_RAW, temp_r0);
    write_reg(REG_TEMP_P1_RAW, temp_r1);
    wr_en <= 1'b0;
  endtask

  // offer a word and hold it until the block takes it; busy is looked at mid-cycle
  task automatic send(logic sel, logic [RAW_W-1:0] sample);
    start              <= 1'b1;
    in_word.cmd        <= sel;
    in_word.raw_sample <= sample;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop offering words until every expected result word has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // calibration points in percent or degrees, with random upper bits to be dropped
  function automatic logic [CFG_DAT_W-1:0] pick_point();
    case ($urandom_range(0, 3))
      0:       return {9'($urandom), 7'h00};
      1:       return {9'($urandom), 7'h7f};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // second raw point: sometimes equal, sometimes a tiny span that saturates
  function automatic logic [RAW_W-1:0] pick_raw_pair(logic [RAW_W-1:0] first);
    case ($urandom_range(0, 5))
      0:       return first;
      1:       return first + 16'($urandom_range(1, 3));
      2:       return first - 16'($urandom_range(1, 3));
      default: return pick_raw();
    endcase
  endfunction

  task automatic random_calibration();
    logic [RAW_W-1:0] hum_r0, temp_r0;
    hum_r0  = pick_raw();
    temp_r0 = pick_raw();
    load_calibration(pick_point(), pick_point(), hum_r0, pick_raw_pair(hum_r0),
                     pick_point(), pick_point(), temp_r0, pick_raw_pair(temp_r0));
  endtask

  function automatic logic [RAW_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // stimulus and verdict
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset calibration: both sets have equal raw points
    send(CMD_TEMP, 16'h1234);
    send(CMD_HUM, 16'h8000);
    wait_drained();

    // full raw range, rising temperature set and falling humidity set
    load_calibration(16'h007f, 16'h0000, 16'h7fff, 16'h8000,
                     16'h0000, 16'h007f, 16'h8000, 16'h7fff);
    send(CMD_TEMP, 16'h8000);
    send(CMD_TEMP, 16'h7fff);
    idle_for(2);
    send(CMD_TEMP, 16'h0000);
    send(CMD_TEMP, 16'hffff);
    send(CMD_HUM, 16'h8000);
    idle_for(1);
    send(CMD_HUM, 16'h7fff);
    send(CMD_HUM, 16'h0000);
    send(CMD_HUM, 16'h0001);
    wait_drained();

    // unit span: saturation both ways, upper bits of the points dropped
    load_calibration(16'h807f, 16'hff00, 16'h0000, 16'h0001,
                     16'hff80, 16'hffff, 16'h0000, 16'h0001);
    send(CMD_TEMP, 16'h7fff);
    send(CMD_TEMP, 16'h8000);
    send(CMD_TEMP, 16'h0001);
    send(CMD_HUM, 16'h7fff);
    send(CMD_HUM, 16'h8000);
    wait_drained();

    // exact half tenths on humidity, equal raw points on temperature
    load_calibration(16'h0000, 16'h0001, 16'h0000, 16'h0014,
                     16'h0005, 16'h0009, 16'h1234, 16'h1234);
    send(CMD_HUM, 16'h0001);
    send(CMD_HUM, 16'hffff);
    send(CMD_HUM, 16'h0003);
    send(CMD_HUM, 16'hfffd);
    send(CMD_TEMP, 16'h1234);

    // random phases, each with its own calibration
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      bit bursty;
      wait_drained();
      random_calibration();
      bursty = ($urandom_range(0, 3) == 0);
      repeat (PHASE_WORDS) begin
        send(logic'($urandom_range(0, 1)), pick_sample());
        if ($urandom_range(0, 149) == 0) wait_drained();
        else if (!bursty) idle_for(pick_gap());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
